@@ hw/rtl/srp_pkg.sv @@
// ----------------------------------------------------------------------------
// srp_pkg: shared types and constants of the search reply record parser
// Parse phases, result kinds, field sizes and the channel payload structs.
// ----------------------------------------------------------------------------
package srp_pkg;

	// Parse phase of the byte walker.
	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_USER_LEN   = 4'd1,
		PH_USER_SKIP  = 4'd2,
		PH_TOKEN      = 4'd3,
		PH_COUNT      = 4'd4,
		PH_CODE       = 4'd5,
		PH_NAME_LEN   = 4'd6,
		PH_NAME       = 4'd7,
		PH_SIZE       = 4'd8,
		PH_ATTR_COUNT = 4'd9,
		PH_ATTR_SKIP  = 4'd10
	} phase_t;

	// Result kinds.
	localparam logic [1:0] KIND_NAME   = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_DROP   = 2'd2;

	// Field sizes in bytes and the index of the last byte of each field.
	localparam logic [31:0] WORD_BYTES    = 32'd4;
	localparam logic [31:0] TRAILER_BYTES = 32'd12; // size plus attribute count
	localparam logic [2:0]  WORD_LAST     = 3'd3;
	localparam logic [2:0]  SIZE_LAST     = 3'd7;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        first_byte;
		logic [31:0] payload_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  name_byte;
		logic [63:0] file_size;
	} out_item_t;

endpackage

@@ hw/rtl/srp_if.sv @@
// ----------------------------------------------------------------------------
// srp_if: valid/ready channels of the search reply record parser
// One interface for the payload byte stream and one for the result stream.
// ----------------------------------------------------------------------------
interface srp_in_if;
	logic             valid;
	logic             ready;
	srp_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface srp_out_if;
	logic               valid;
	logic               ready;
	srp_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/search_reply_record_parser.sv @@
// ----------------------------------------------------------------------------
// search_reply_record_parser: byte-serial parser of search reply records
// The result of a byte is registered and appears on the result channel in the cycle after the byte is accepted.
// Throughput: one payload byte per cycle while no waiting result is stalled; the
// parse state is updated in the same cycle a byte transfer completes.
// Reset: arst_n clears the parser to idle and empties the result register.
// ----------------------------------------------------------------------------
module search_reply_record_parser (
	input  logic            clk,
	input  logic            arst_n,
	srp_in_if.sink          rx,
	srp_out_if.source       result
);

	// The parser keeps the walk through the payload in a handful of
	// registers. Each accepted byte moves the walk one step: the next state
	// and an optional result are computed combinationally from the current
	// state and the byte, and the result goes into a single output register.
	// A byte is taken whenever that register is empty or is being drained in
	// the same cycle, so a stream without back-pressure runs at full rate.

	srp_pkg::phase_t phase_q;
	logic [31:0]     bytes_left_q;
	logic [31:0]     field_value_q;
	logic [2:0]      field_idx_q;
	logic [31:0]     skip_left_q;
	logic [31:0]     records_left_q;
	logic [63:0]     size_value_q;

	logic               out_valid_q;
	srp_pkg::out_item_t out_item_q;

	logic rx_fire;

	// Next-state values and the result of the byte at hand.
	srp_pkg::phase_t phase_d;
	logic [31:0]     bytes_left_d;
	logic [31:0]     field_value_d;
	logic [2:0]      field_idx_d;
	logic [31:0]     skip_left_d;
	logic [31:0]     records_left_d;
	logic [63:0]     size_value_d;
	logic            emit_c;
	logic [1:0]      kind_c;
	logic [7:0]      name_c;
	logic [63:0]     size_c;

	assign rx.ready     = !out_valid_q || result.ready;
	assign rx_fire      = rx.valid && rx.ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_item_q;

	always_comb begin
		srp_pkg::phase_t phase_cur;
		logic [31:0]     bl_cur;
		logic [31:0]     bl1;
		logic [31:0]     fv_cur;
		logic [2:0]      idx_cur;
		logic [31:0]     word_v;
		logic            word_done;
		logic [2:0]      word_idx;
		logic [31:0]     skip_dec;
		logic [31:0]     rec_dec;
		logic [34:0]     attr_bytes;
		logic [31:0]     name_room;
		logic [7:0]      b;

		b = rx.data.payload_byte;

		phase_d        = phase_q;
		bytes_left_d   = bytes_left_q;
		field_value_d  = field_value_q;
		field_idx_d    = field_idx_q;
		skip_left_d    = skip_left_q;
		records_left_d = records_left_q;
		size_value_d   = size_value_q;
		emit_c         = 1'b0;
		kind_c         = srp_pkg::KIND_NAME;
		name_c         = 8'd0;
		size_c         = 64'd0;

		// A first byte restarts the walk at the user name length.
		if (rx.data.first_byte) begin
			phase_cur = srp_pkg::PH_USER_LEN;
			bl_cur    = rx.data.payload_length;
			fv_cur    = 32'd0;
			idx_cur   = 3'd0;
		end else begin
			phase_cur = phase_q;
			bl_cur    = bytes_left_q;
			fv_cur    = field_value_q;
			idx_cur   = field_idx_q;
		end

		bl1        = bl_cur - 32'd1;
		word_v     = fv_cur | ({24'd0, b} << {idx_cur[1:0], 3'b000});
		word_done  = idx_cur >= srp_pkg::WORD_LAST;
		word_idx   = word_done ? 3'd0 : idx_cur + 3'd1;
		skip_dec   = skip_left_q - 32'd1;
		rec_dec    = records_left_q - 32'd1;
		attr_bytes = {word_v, 3'b000};
		name_room  = bl1 - word_v;

		if (rx.data.first_byte) begin
			bytes_left_d  = rx.data.payload_length;
			field_value_d = 32'd0;
			field_idx_d   = 3'd0;
			phase_d       = srp_pkg::PH_USER_LEN;
		end

		if (rx.data.first_byte && rx.data.payload_length < srp_pkg::WORD_BYTES) begin
			// Too short to hold even the user name length.
			phase_d = srp_pkg::PH_IDLE;
		end else if (phase_cur == srp_pkg::PH_IDLE || bl_cur == 32'd0) begin
			phase_d = srp_pkg::PH_IDLE;
		end else begin
			bytes_left_d = bl1;
			case (phase_cur)
				srp_pkg::PH_USER_LEN: begin
					field_value_d = word_v;
					field_idx_d   = word_idx;
					if (word_done) begin
						if (word_v > bl1) begin
							phase_d = srp_pkg::PH_IDLE;
						end else if (word_v == 32'd0) begin
							if (bl1 < srp_pkg::WORD_BYTES) begin
								phase_d = srp_pkg::PH_IDLE;
							end else begin
								phase_d       = srp_pkg::PH_TOKEN;
								field_value_d = 32'd0;
								field_idx_d   = 3'd0;
							end
						end else begin
							skip_left_d = word_v;
							phase_d     = srp_pkg::PH_USER_SKIP;
						end
					end
				end
				srp_pkg::PH_USER_SKIP: begin
					skip_left_d = skip_dec;
					if (skip_dec == 32'd0) begin
						if (bl1 < srp_pkg::WORD_BYTES) begin
							phase_d = srp_pkg::PH_IDLE;
						end else begin
							phase_d       = srp_pkg::PH_TOKEN;
							field_value_d = 32'd0;
							field_idx_d   = 3'd0;
						end
					end
				end
				srp_pkg::PH_TOKEN: begin
					field_value_d = word_v;
					field_idx_d   = word_idx;
					if (word_done) begin
						if (bl1 < srp_pkg::WORD_BYTES) begin
							phase_d = srp_pkg::PH_IDLE;
						end else begin
							phase_d       = srp_pkg::PH_COUNT;
							field_value_d = 32'd0;
							field_idx_d   = 3'd0;
						end
					end
				end
				srp_pkg::PH_COUNT: begin
					field_value_d = word_v;
					field_idx_d   = word_idx;
					if (word_done) begin
						records_left_d = word_v;
						if (word_v == 32'd0 || bl1 == 32'd0) begin
							phase_d = srp_pkg::PH_IDLE;
						end else begin
							phase_d = srp_pkg::PH_CODE;
						end
					end
				end
				srp_pkg::PH_CODE: begin
					if (bl1 < srp_pkg::WORD_BYTES) begin
						phase_d = srp_pkg::PH_IDLE;
						emit_c  = 1'b1;
						kind_c  = srp_pkg::KIND_DROP;
					end else begin
						phase_d       = srp_pkg::PH_NAME_LEN;
						field_value_d = 32'd0;
						field_idx_d   = 3'd0;
					end
				end
				srp_pkg::PH_NAME_LEN: begin
					field_value_d = word_v;
					field_idx_d   = word_idx;
					if (word_done) begin
						// The name, the size and the attribute count must all fit.
						if (word_v > bl1 || name_room < srp_pkg::TRAILER_BYTES) begin
							phase_d = srp_pkg::PH_IDLE;
							emit_c  = 1'b1;
							kind_c  = srp_pkg::KIND_DROP;
						end else if (word_v == 32'd0) begin
							phase_d      = srp_pkg::PH_SIZE;
							size_value_d = 64'd0;
							field_idx_d  = 3'd0;
						end else begin
							skip_left_d = word_v;
							phase_d     = srp_pkg::PH_NAME;
						end
					end
				end
				srp_pkg::PH_NAME: begin
					skip_left_d = skip_dec;
					if (skip_dec == 32'd0) begin
						phase_d      = srp_pkg::PH_SIZE;
						size_value_d = 64'd0;
						field_idx_d  = 3'd0;
					end
					emit_c = 1'b1;
					kind_c = srp_pkg::KIND_NAME;
					name_c = b;
				end
				srp_pkg::PH_SIZE: begin
					size_value_d = size_value_q | ({56'd0, b} << {idx_cur, 3'b000});
					if (idx_cur >= srp_pkg::SIZE_LAST) begin
						if (bl1 < srp_pkg::WORD_BYTES) begin
							phase_d = srp_pkg::PH_IDLE;
						end else begin
							phase_d       = srp_pkg::PH_ATTR_COUNT;
							field_value_d = 32'd0;
							field_idx_d   = 3'd0;
						end
					end else begin
						field_idx_d = idx_cur + 3'd1;
					end
				end
				srp_pkg::PH_ATTR_COUNT: begin
					field_value_d = word_v;
					field_idx_d   = word_idx;
					if (word_done) begin
						emit_c = 1'b1;
						if (attr_bytes > {3'd0, bl1}) begin
							phase_d = srp_pkg::PH_IDLE;
							kind_c  = srp_pkg::KIND_DROP;
						end else begin
							kind_c = srp_pkg::KIND_ACCEPT;
							size_c = size_value_q;
							if (attr_bytes == 35'd0) begin
								records_left_d = rec_dec;
								if (rec_dec == 32'd0 || bl1 == 32'd0) begin
									phase_d = srp_pkg::PH_IDLE;
								end else begin
									phase_d = srp_pkg::PH_CODE;
								end
							end else begin
								skip_left_d = attr_bytes[31:0];
								phase_d     = srp_pkg::PH_ATTR_SKIP;
							end
						end
					end
				end
				srp_pkg::PH_ATTR_SKIP: begin
					skip_left_d = skip_dec;
					if (skip_dec == 32'd0) begin
						records_left_d = rec_dec;
						if (rec_dec == 32'd0 || bl1 == 32'd0) begin
							phase_d = srp_pkg::PH_IDLE;
						end else begin
							phase_d = srp_pkg::PH_CODE;
						end
					end
				end
				default: begin
					phase_d = srp_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// Parse state advances only on a completed byte transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= srp_pkg::PH_IDLE;
			bytes_left_q   <= 32'd0;
			field_value_q  <= 32'd0;
			field_idx_q    <= 3'd0;
			skip_left_q    <= 32'd0;
			records_left_q <= 32'd0;
			size_value_q   <= 64'd0;
		end else if (rx_fire) begin
			phase_q        <= phase_d;
			bytes_left_q   <= bytes_left_d;
			field_value_q  <= field_value_d;
			field_idx_q    <= field_idx_d;
			skip_left_q    <= skip_left_d;
			records_left_q <= records_left_d;
			size_value_q   <= size_value_d;
		end
	end

	// Result register: filled by a byte that yields a result, emptied by a
	// result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rx_fire) begin
			out_valid_q <= emit_c;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire && emit_c) begin
			out_item_q.result_kind <= kind_c;
			out_item_q.name_byte   <= name_c;
			out_item_q.file_size   <= size_c;
		end
	end

`ifndef SYNTHESIS
	// A waiting result is never overwritten by a new byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !rx.ready)
		else $error("byte accepted while result register is stalled");

	// A byte that is not a first byte does nothing while the parser is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rx_fire && !rx.data.first_byte && phase_q == srp_pkg::PH_IDLE) |=> !result.valid)
		else $error("result produced while idle");

	// Name bytes come only from the name phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rx_fire && emit_c && kind_c == srp_pkg::KIND_NAME) |->
		(phase_q == srp_pkg::PH_NAME && !rx.data.first_byte))
		else $error("name byte outside the name phase");

	// Only defined result kinds leave the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.result_kind == srp_pkg::KIND_NAME ||
		result.data.result_kind == srp_pkg::KIND_ACCEPT ||
		result.data.result_kind == srp_pkg::KIND_DROP))
		else $error("undefined result kind");
`endif

endmodule
